### rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared widths, beat types and the full-wave sine table builder for the
// Clarke-Park current transform.
// ----------------------------------------------------------------------------
package cpt_pkg;

  // Field widths and formats
  localparam int SAMPLE_W    = 16;
  localparam int ANGLE_W     = 16;
  localparam int TRIG_W      = 16;
  localparam int SINE_DEPTH  = 512;
  localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
  localparam int SINE_FRAC_W = ANGLE_W - SINE_IDX_W;

  // Clarke stage: beta keeps BETA_SHIFT extra fraction bits
  localparam int COEF_W      = 31;
  localparam logic [COEF_W-1:0] INV_SQRT3_Q30 = 31'd619925131;
  localparam int BETA_SHIFT  = 15;
  localparam int SUM_W       = SAMPLE_W + 2;
  localparam int BETA_PROD_W = SUM_W + COEF_W + 1;
  localparam int BETA_W      = SAMPLE_W + 16;

  // Park stage: sums carry PARK_SHIFT extra fraction bits
  localparam int PARK_SHIFT  = 30;
  localparam int PARK_W      = BETA_W + TRIG_W + 1;

  // Accept edge to result strobe, in cycles
  localparam int PIPE_DEPTH  = 6;

  // Table generation constants (elaboration only)
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam longint      ONE_Q30     = 64'sd1073741824;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [ANGLE_W-1:0]  angle_t;
  typedef logic signed [TRIG_W-1:0]   trig_t;
  typedef logic signed [BETA_W-1:0]   beta_t;
  typedef logic        [SINE_IDX_W-1:0] sine_idx_t;
  typedef trig_t sine_lut_t [SINE_DEPTH];

  localparam angle_t QUARTER_TURN = angle_t'(1 << (ANGLE_W - 2));

  // Input beat
  typedef struct packed {
    sample_t phase_a_current;
    sample_t phase_b_current;
    angle_t  rotor_angle;
  } cpt_in_t;

  // Result beat
  typedef struct packed {
    sample_t direct_current;
    sample_t quadrature_current;
  } cpt_out_t;

  // Interpolated sine and cosine, Q15
  typedef struct packed {
    trig_t sin_val;
    trig_t cos_val;
  } sincos_t;

  // Clarke output toward the Park stage
  typedef struct packed {
    logic    valid;
    sample_t ia;
    beta_t   beta;
  } clarke_t;

  // Clamp a Q30 value to 0..1 and scale to Q15 amplitude 32767
  function automatic trig_t q30_to_q15(longint sum);
    longint      clamped;
    logic [63:0] scaled;
    clamped = sum;
    if (clamped < 0) clamped = 0;
    if (clamped > ONE_Q30) clamped = ONE_Q30;
    scaled = (64'(clamped) * 64'd32767 + 64'd536870912) >> 30;
    return trig_t'(scaled[TRIG_W-1:0]);
  endfunction

  // Taylor series for sine, x in Q30 radians, first quadrant
  function automatic trig_t quarter_sine(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(term);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
    return q30_to_q15(sum);
  endfunction

  // Taylor series for cosine, x in Q30 radians, first quadrant
  function automatic trig_t quarter_cosine(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x) >> 30;
    term = 64'(ONE_Q30);
    sum  = longint'(term);
    term = ((term * x2) >> 30) / 64'd2;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd12;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd30;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd56;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd90;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd132; sum = sum + longint'(term);
    return q30_to_q15(sum);
  endfunction

  // Full-wave sine table, folded onto the first quadrant
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t   lut;
    logic [63:0] four_k;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] x;
    trig_t       v;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      four_k = 64'(4 * k);
      quad   = four_k / SINE_DEPTH;
      rem    = four_k - quad * SINE_DEPTH;
      x      = rem * HALF_PI_Q30 / SINE_DEPTH;
      unique case (quad[1:0])
        2'd0: v = quarter_sine(x);
        2'd1: v = quarter_cosine(x);
        2'd2: v = -quarter_sine(x);
        2'd3: v = -quarter_cosine(x);
      endcase
      lut[k] = v;
    end
    return lut;
  endfunction

endpackage

### rtl/cpt_sine_rom.sv
// ----------------------------------------------------------------------------
// cpt_sine_rom
// Constant sine table with two read ports and registered read data.
// ----------------------------------------------------------------------------
module cpt_sine_rom import cpt_pkg::*; (
  input  logic      clk_i,
  input  sine_idx_t addr_a_i,
  input  sine_idx_t addr_b_i,
  output trig_t     data_a_o,
  output trig_t     data_b_o
);

  localparam sine_lut_t SINE_LUT = build_sine_lut();

  trig_t data_a_q;
  trig_t data_b_q;

  // Read both ports every cycle
  always_ff @(posedge clk_i) begin
    data_a_q <= SINE_LUT[addr_a_i];
    data_b_q <= SINE_LUT[addr_b_i];
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

### rtl/cpt_sincos.sv
// ----------------------------------------------------------------------------
// cpt_sincos
// Sine and cosine of the rotor angle by table lookup and linear
// interpolation: table read, slope multiply, rounded add (three stages).
// ----------------------------------------------------------------------------
module cpt_sincos import cpt_pkg::*; (
  input  logic    clk_i,
  input  angle_t  angle_i,
  output sincos_t trig_o
);

  localparam int DIFF_W = TRIG_W + 1;
  localparam int PROD_W = DIFF_W + SINE_FRAC_W + 1;
  localparam logic signed [PROD_W-1:0] INTERP_RND = PROD_W'(1 << (SINE_FRAC_W - 1));

  // Lane 0 is sine, lane 1 is cosine (angle a quarter turn ahead)
  angle_t lane_angle [2];
  trig_t  trig_q     [2];

  assign lane_angle[0] = angle_i;
  assign lane_angle[1] = angle_t'(angle_i + QUARTER_TURN);

  for (genvar l = 0; l < 2; l++) begin : g_lane
    sine_idx_t                  idx;
    trig_t                      base;
    trig_t                      nxt;
    logic [SINE_FRAC_W-1:0]     frac_q;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod_d;
    logic signed [PROD_W-1:0]   prod_q;
    logic signed [PROD_W-1:0]   step;
    trig_t                      base_q;
    trig_t                      trig_d;

    assign idx = lane_angle[l][ANGLE_W-1 -: SINE_IDX_W];

    // Stage 1: fetch the two neighboring entries, last entry wraps to zero
    cpt_sine_rom u_rom (
      .clk_i    (clk_i),
      .addr_a_i (idx),
      .addr_b_i (sine_idx_t'(idx + 1'b1)),
      .data_a_o (base),
      .data_b_o (nxt)
    );

    always_ff @(posedge clk_i) begin
      frac_q <= lane_angle[l][SINE_FRAC_W-1:0];
    end

    // Stage 2: slope times fraction
    assign diff   = $signed({nxt[TRIG_W-1], nxt}) - $signed({base[TRIG_W-1], base});
    assign prod_d = diff * $signed({1'b0, frac_q});

    always_ff @(posedge clk_i) begin
      prod_q <= prod_d;
      base_q <= base;
    end

    // Stage 3: round to nearest, ties upward, and add the base entry
    assign step   = (prod_q + INTERP_RND) >>> SINE_FRAC_W;
    assign trig_d = trig_t'(base_q + step[TRIG_W-1:0]);

    always_ff @(posedge clk_i) begin
      trig_q[l] <= trig_d;
    end
  end

  assign trig_o.sin_val = trig_q[0];
  assign trig_o.cos_val = trig_q[1];

endmodule

### rtl/cpt_clarke.sv
// ----------------------------------------------------------------------------
// cpt_clarke
// Clarke transform: beta = (Ia + 2*Ib) / sqrt(3) with 15 extra fraction
// bits; sum, constant multiply, rounding (three stages).
// ----------------------------------------------------------------------------
module cpt_clarke import cpt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  sample_t ia_i,
  input  sample_t ib_i,
  output clarke_t cl_o
);

  localparam logic signed [COEF_W:0] INV_SQRT3_S = {1'b0, INV_SQRT3_Q30};
  localparam logic signed [BETA_PROD_W-1:0] BETA_RND =
    BETA_PROD_W'(1 << (BETA_SHIFT - 1));

  logic [2:0]                     valid_q;
  sample_t                        ia1_q;
  sample_t                        ia2_q;
  sample_t                        ia3_q;
  logic signed [SUM_W-1:0]        sum_d;
  logic signed [SUM_W-1:0]        sum_q;
  logic signed [BETA_PROD_W-1:0]  beta_prod_d;
  logic signed [BETA_PROD_W-1:0]  beta_prod_q;
  logic signed [BETA_PROD_W-1:0]  beta_rnd;
  beta_t                          beta_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // Stage 1: Ia + 2*Ib
  assign sum_d = SUM_W'(ia_i) + (SUM_W'(ib_i) <<< 1);

  // Stage 2: scale by 1/sqrt(3)
  assign beta_prod_d = sum_q * INV_SQRT3_S;

  // Stage 3: drop 15 fraction bits, round to nearest
  assign beta_rnd = (beta_prod_q + BETA_RND) >>> BETA_SHIFT;

  always_ff @(posedge clk_i) begin
    sum_q       <= sum_d;
    ia1_q       <= ia_i;
    beta_prod_q <= beta_prod_d;
    ia2_q       <= ia1_q;
    beta_q      <= beta_rnd[BETA_W-1:0];
    ia3_q       <= ia2_q;
  end

  assign cl_o.valid = valid_q[2];
  assign cl_o.ia    = ia3_q;
  assign cl_o.beta  = beta_q;

  // Rounded beta always fits its narrower register
  a_beta_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> ((&beta_rnd[BETA_PROD_W-1:BETA_W-1]) ||
                    !(|beta_rnd[BETA_PROD_W-1:BETA_W-1])))
    else $error("beta overflows its register");

endmodule

### rtl/cpt_park.sv
// ----------------------------------------------------------------------------
// cpt_park
// Park rotation: four products, rounded sums, shift and saturate
// (three stages).
// ----------------------------------------------------------------------------
module cpt_park import cpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  clarke_t  cl_i,
  input  sincos_t  trig_i,
  output logic     valid_o,
  output cpt_out_t res_o
);

  localparam int IA_PROD_W   = SAMPLE_W + TRIG_W;
  localparam int BETA_PROD_W2 = BETA_W + TRIG_W;
  localparam logic signed [PARK_W-1:0] PARK_RND = PARK_W'(64'd1 << (PARK_SHIFT - 1));
  localparam logic signed [PARK_W-1:0] SAT_MAX  = PARK_W'((64'd1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [PARK_W-1:0] SAT_MIN  = ~SAT_MAX;
  localparam trig_t TRIG_MIN = {1'b1, {(TRIG_W-1){1'b0}}};

  logic [2:0]                      valid_q;
  logic signed [IA_PROD_W-1:0]     ia_cos_q;
  logic signed [IA_PROD_W-1:0]     ia_sin_q;
  logic signed [BETA_PROD_W2-1:0]  beta_sin_q;
  logic signed [BETA_PROD_W2-1:0]  beta_cos_q;
  logic signed [PARK_W-1:0]        d_sum_d;
  logic signed [PARK_W-1:0]        q_sum_d;
  logic signed [PARK_W-1:0]        d_sum_q;
  logic signed [PARK_W-1:0]        q_sum_q;
  logic signed [PARK_W-1:0]        d_shift;
  logic signed [PARK_W-1:0]        q_shift;
  cpt_out_t                        res_q;

  // Clamp to the sample range
  function automatic sample_t saturate(logic signed [PARK_W-1:0] v);
    sample_t r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[SAMPLE_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], cl_i.valid};
    end
  end

  // Stage 2: align Ia terms to beta's fraction, add, add rounding offset
  assign d_sum_d = (PARK_W'(ia_cos_q) <<< BETA_SHIFT) + PARK_W'(beta_sin_q) + PARK_RND;
  assign q_sum_d = PARK_W'(beta_cos_q) - (PARK_W'(ia_sin_q) <<< BETA_SHIFT) + PARK_RND;

  // Stage 3: drop the fraction
  assign d_shift = d_sum_q >>> PARK_SHIFT;
  assign q_shift = q_sum_q >>> PARK_SHIFT;

  always_ff @(posedge clk_i) begin
    // Stage 1: products
    ia_cos_q   <= $signed(cl_i.ia) * $signed(trig_i.cos_val);
    ia_sin_q   <= $signed(cl_i.ia) * $signed(trig_i.sin_val);
    beta_sin_q <= $signed(cl_i.beta) * $signed(trig_i.sin_val);
    beta_cos_q <= $signed(cl_i.beta) * $signed(trig_i.cos_val);
    d_sum_q    <= d_sum_d;
    q_sum_q    <= q_sum_d;
    res_q.direct_current     <= saturate(d_shift);
    res_q.quadrature_current <= saturate(q_shift);
  end

  assign valid_o = valid_q[2];
  assign res_o   = res_q;

  // Interpolated table values never reach the most negative code
  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cl_i.valid |-> (trig_i.sin_val != TRIG_MIN) && (trig_i.cos_val != TRIG_MIN))
    else $error("sine or cosine out of Q15 amplitude range");

  // Each result comes from a valid beat that passed the product, sum and result registers
  a_park_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(cl_i.valid, 3))
    else $error("park result without matching input");

endmodule

### rtl/clarke_park_current_transform.sv
// ----------------------------------------------------------------------------
// clarke_park_current_transform
// A result strobes on done_o once its start beat has passed the Clarke and sine stages, then Park.
// Throughput: one beat per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the table read, interpolation and Park multiply stages.
// Reset (rst_ni low, asynchronous) drops all beats in flight.
// ----------------------------------------------------------------------------
module clarke_park_current_transform import cpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  cpt_in_t  in_i,
  output logic     done_o,
  output cpt_out_t res_o
);

  logic    accept;
  clarke_t cl;
  sincos_t trig;

  // Always ready for a new beat
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Sine and cosine of the rotor angle
  cpt_sincos u_sincos (
    .clk_i   (clk_i),
    .angle_i (in_i.rotor_angle),
    .trig_o  (trig)
  );

  // Alpha/beta currents
  cpt_clarke u_clarke (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .ia_i    (in_i.phase_a_current),
    .ib_i    (in_i.phase_b_current),
    .cl_o    (cl)
  );

  // Rotate into the d/q frame
  cpt_park u_park (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cl_i    (cl),
    .trig_i  (trig),
    .valid_o (done_o),
    .res_o   (res_o)
  );

  // Every accepted beat yields exactly one strobe on done_o
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PIPE_DEPTH done_o)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, PIPE_DEPTH))
    else $error("result without accepted beat");

endmodule

### tb/sv/cpt_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpt_result_checker
// Watches the start and done channels of the Clarke-Park current transform.
// For every accepted start beat it computes the expected d/q currents with an
// independent fixed-point model: its own Taylor-built sine table, linear
// interpolation, Clarke and Park math and saturation. Each done beat is
// compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module cpt_result_checker import cpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     busy,
  input  cpt_in_t  in_i,
  input  logic     done_o,
  input  cpt_out_t res_o,
  output int       err_cnt_o,
  output int       pend_cnt_o,
  output int       chk_cnt_o,
  output int       sat_cnt_o
);

  typedef logic signed [15:0] q15_t;

  localparam int          LUT_DEPTH      = 512;
  localparam int          LUT_IDX_W      = 9;
  localparam logic [63:0] QTR_PI_Q30     = 64'd1686629713;  // pi/2 in Q30
  localparam logic [63:0] UNITY_Q30      = 64'd1073741824;
  localparam longint      RSQRT3_Q30     = 64'sd619925131;  // 1/sqrt(3) in Q30
  localparam logic [15:0] ANGLE_QUARTER  = 16'h4000;
  localparam longint      OUT_MAX        = 32767;
  localparam longint      OUT_MIN        = -32768;

  typedef struct {
    cpt_in_t  src;
    cpt_out_t want;
  } dq_expect_t;

  q15_t       sine_lut [LUT_DEPTH];
  dq_expect_t pending_dq_q [$];
  int         err_cnt = 0;
  int         chk_cnt = 0;
  int         sat_cnt = 0;
  int         pend    = 0;

  assign err_cnt_o  = err_cnt;
  assign pend_cnt_o = pend;
  assign chk_cnt_o  = chk_cnt;
  assign sat_cnt_o  = sat_cnt;

  // Round v / 2^sh to nearest, ties toward +infinity
  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // First-quadrant sine or cosine by Taylor series in Q30, scaled to Q15
  function automatic q15_t taylor_q15(logic [63:0] x, bit cos_mode);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] div;
    longint      acc;
    x2   = (x * x) >> 30;
    term = cos_mode ? UNITY_Q30 : x;
    acc  = longint'(term);
    for (int n = 1; n <= 6; n++) begin
      div  = cos_mode ? 64'((2 * n - 1) * (2 * n)) : 64'((2 * n) * (2 * n + 1));
      term = ((term * x2) >> 30) / div;
      if (n % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(UNITY_Q30)) acc = longint'(UNITY_Q30);
    return q15_t'((64'(acc) * 64'd32767 + 64'd536870912) >> 30);
  endfunction

  // One full-wave table point, folded onto the first quadrant
  function automatic q15_t lut_point(int k);
    logic [63:0] quad;
    logic [63:0] offs;
    logic [63:0] x;
    quad = 64'((4 * k) / LUT_DEPTH);
    offs = 64'((4 * k) % LUT_DEPTH);
    x    = offs * QTR_PI_Q30 / 64'(LUT_DEPTH);
    case (quad[1:0])
      2'd0:    return taylor_q15(x, 1'b0);
      2'd1:    return taylor_q15(x, 1'b1);
      2'd2:    return -taylor_q15(x, 1'b0);
      default: return -taylor_q15(x, 1'b1);
    endcase
  endfunction

  // Interpolated sine at a 16-bit turn fraction; the last entry wraps to 0
  function automatic longint lut_interp(logic [15:0] ang);
    logic [LUT_IDX_W-1:0] idx;
    logic [LUT_IDX_W-1:0] nxt;
    longint               base;
    longint               diff;
    longint               frac;
    idx  = ang[15 -: LUT_IDX_W];
    nxt  = idx + 1'b1;
    frac = longint'({ang[15-LUT_IDX_W:0], 9'b0});
    base = longint'(sine_lut[idx]);
    diff = longint'(sine_lut[nxt]) - base;
    return round_shift(base * 65536 + diff * frac, 16);
  endfunction

  function automatic sample_t clamp_q15(longint v, inout bit clipped);
    if (v > OUT_MAX) begin
      clipped = 1'b1;
      return sample_t'(OUT_MAX);
    end
    if (v < OUT_MIN) begin
      clipped = 1'b1;
      return sample_t'(OUT_MIN);
    end
    return sample_t'(v);
  endfunction

  // Clarke then Park on one input beat
  function automatic cpt_out_t predict_dq_currents(cpt_in_t beat, output bit clipped);
    longint      ia;
    longint      ib;
    longint      sn;
    longint      cs;
    longint      beta;
    logic [15:0] ang_cos;
    cpt_out_t    dq;
    clipped = 1'b0;
    ia      = longint'(beat.phase_a_current);
    ib      = longint'(beat.phase_b_current);
    ang_cos = beat.rotor_angle + ANGLE_QUARTER;
    sn      = lut_interp(beat.rotor_angle);
    cs      = lut_interp(ang_cos);
    beta    = round_shift((ia + 2 * ib) * RSQRT3_Q30, 15);
    dq.direct_current =
      clamp_q15(round_shift(ia * cs * 32768 + beta * sn, 30), clipped);
    dq.quadrature_current =
      clamp_q15(round_shift(beta * cs - ia * sn * 32768, 30), clipped);
    return dq;
  endfunction

  // Build the table once
  initial begin
    for (int k = 0; k < LUT_DEPTH; k++) sine_lut[k] = lut_point(k);
  end

  function automatic void report(string what, sample_t exp_v, sample_t got_v, cpt_in_t src);
    err_cnt++;
    $display("%0t: %s expected %0d, got %0d (ia=%0d ib=%0d angle=%0d)", $time, what,
             exp_v, got_v, src.phase_a_current, src.phase_b_current, src.rotor_angle);
  endfunction

  // Retire done beats first, then queue the new start beat
  always @(posedge clk_i or negedge rst_ni) begin
    dq_expect_t entry;
    bit         clipped;
    if (!rst_ni) begin
      pending_dq_q.delete();
      pend = 0;
    end else begin
      if (done_o) begin
        if (pending_dq_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result beat with nothing expected: d=%0d q=%0d", $time,
                   res_o.direct_current, res_o.quadrature_current);
        end else begin
          entry = pending_dq_q.pop_front();
          chk_cnt++;
          if (res_o.direct_current !== entry.want.direct_current)
            report("direct_current", entry.want.direct_current,
                   res_o.direct_current, entry.src);
          if (res_o.quadrature_current !== entry.want.quadrature_current)
            report("quadrature_current", entry.want.quadrature_current,
                   res_o.quadrature_current, entry.src);
        end
      end
      if (start && !busy) begin
        entry.src  = in_i;
        entry.want = predict_dq_currents(in_i, clipped);
        if (clipped) sat_cnt++;
        pending_dq_q.push_back(entry);
      end
      pend = pending_dq_q.size();
    end
  end

endmodule

### tb/sv/tb_clarke_park_current_transform.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clarke_park_current_transform
// Drives the Clarke-Park current transform with directed corner beats
// (full-scale currents, quadrant and table-wrap angles, saturation) and then
// random beats with bursty start gaps. A separate checker predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_clarke_park_current_transform import cpt_pkg::*; ();

  localparam int NUM_RANDOM    = 1330;
  localparam int QUIET_TAIL    = 150;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RESET_CYCLES  = 6;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  cpt_in_t  in_i   = '0;
  logic     done_o;
  cpt_out_t res_o;

  int err_cnt;
  int pend_cnt;
  int chk_cnt;
  int sat_cnt;
  int sent_cnt     = 0;
  int directed_cnt = 0;
  int quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  clarke_park_current_transform uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  cpt_result_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .err_cnt_o  (err_cnt),
    .pend_cnt_o (pend_cnt),
    .chk_cnt_o  (chk_cnt),
    .sat_cnt_o  (sat_cnt)
  );

  function automatic cpt_in_t mk_beat(int ia, int ib, int ang);
    cpt_in_t beat;
    beat.phase_a_current = 16'(ia);
    beat.phase_b_current = 16'(ib);
    beat.rotor_angle     = 16'(ang);
    return beat;
  endfunction

  // Current sample biased toward full scale and near zero
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(0, 511) - 256);
      3: begin
        if ($urandom_range(0, 1) != 0) return 16'(32767 - $urandom_range(0, 300));
        return 16'(32'h8000 + $urandom_range(0, 300));
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Angle biased toward table points, segment ends, quadrants and the wrap
  function automatic angle_t pick_angle();
    angle_t ang;
    ang = 16'($urandom);
    case ($urandom_range(0, 7))
      0:       return {ang[15:7], 7'd0};
      1:       return {ang[15:7], 7'h7F};
      2:       return {ang[1:0], 14'd0};
      3:       return 16'hFF80 | 16'($urandom_range(0, 127));
      default: return ang;
    endcase
  endfunction

  function automatic cpt_in_t rand_beat();
    cpt_in_t beat;
    beat.phase_a_current = pick_sample();
    beat.phase_b_current = pick_sample();
    beat.rotor_angle     = pick_angle();
    return beat;
  endfunction

  // Present one beat from a falling edge and hold it until accepted
  task automatic send_beat(input cpt_in_t beat);
    start = 1'b1;
    in_i  = beat;
    do @(posedge clk_i); while (busy);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // Drop start for a burst, with junk on the data bus
  task automatic hold_off(input int cycles);
    start = 1'b0;
    in_i  = rand_beat();
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
  endtask

  // Abort when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else                            quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still outstanding", $time, pend_cnt);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cpt_in_t corner_q [$];
    bit      gaps_on;

    // Hold reset, then release on a falling edge
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Corner beats: full scale, quadrants, segment ends and the table wrap
    corner_q.push_back(mk_beat(0, 0, 0));
    corner_q.push_back(mk_beat(32767, 32767, 0));
    corner_q.push_back(mk_beat(-32768, -32768, 0));
    corner_q.push_back(mk_beat(32767, -32768, 16384));
    corner_q.push_back(mk_beat(-32768, 32767, 32768));
    corner_q.push_back(mk_beat(32767, 32767, 49152));
    corner_q.push_back(mk_beat(-32768, -32768, 8192));
    corner_q.push_back(mk_beat(32767, 32767, 57344));
    corner_q.push_back(mk_beat(12345, -6789, 1));
    corner_q.push_back(mk_beat(-1, -1, 127));
    corner_q.push_back(mk_beat(1, 1, 128));
    corner_q.push_back(mk_beat(32767, 0, 16383));
    corner_q.push_back(mk_beat(0, 32767, 65408));
    corner_q.push_back(mk_beat(-32768, 0, 65535));
    corner_q.push_back(mk_beat(0, -32768, 65535));
    corner_q.push_back(mk_beat(16384, -16384, 24576));
    corner_q.push_back(mk_beat(-20000, 30000, 40000));
    corner_q.push_back(mk_beat(32767, -16384, 5461));
    corner_q.push_back(mk_beat(-32768, 16384, 21845));
    corner_q.push_back(mk_beat(32767, 32767, 65535));
    corner_q.push_back(mk_beat(-32768, -32768, 32767));
    foreach (corner_q[i]) begin
      if (i % 5 == 4) hold_off($urandom_range(1, 8));
      send_beat(corner_q[i]);
    end
    directed_cnt = corner_q.size();
    wait_drained();

    // Random beats: bursty gaps in some stretches, none in the tail
    gaps_on = 1'b1;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 2) wait_drained();
      if (i % 128 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (gaps_on && i < NUM_RANDOM - QUIET_TAIL && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 8));
      send_beat(rand_beat());
    end

    // Drain and let any stray result show up
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d beats (%0d corner, rest random with bursty gaps)", sent_cnt,
             directed_cnt);
    $display("Checked %0d d/q results, %0d of them clipped at full scale", chk_cnt, sat_cnt);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
